// File: rtl/core/mig_pkg.sv
`default_nettype none
package mig_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = MAX_DIM * MAX_DIM;
  localparam int AW        = $clog2(CELLS);
  localparam int TW        = AW + 1;
  localparam int DW        = $clog2(MAX_DIM);
  localparam int NW        = $clog2(MAX_DIM + 1);
  localparam int QW        = 32 + FRAC_BITS;
  localparam int CW        = $clog2(QW + 1);

  localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  localparam logic REG_MATRIX_SIZE = 1'b0;

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [31:0] mag(input logic signed [31:0] v);
    mag = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/matrix_inverse_gauss_jordan_unit.sv
`default_nettype none
// Matrix inverse by Gauss-Jordan elimination, without row exchange.
// The matrix size is set through the APB port (register 0, bits 3:0); a write
// restarts loading. Elements arrive on the input channel in row-major order,
// one signed Q16.16 item per accepted transfer, one item per cycle while
// loading. After the last element the block stalls its input and inverts the
// matrix with one shared restoring divider (one quotient bit per cycle, 48
// steps a division) and one 32 by 32 multiplier. The inverse then leaves in
// row-major order, the next item being read only once the last is taken, with
// an overflow flag on saturated elements and last on the final item.
// A zero pivot gives a single item instead, with singular and last set.
// A stalled result is held unchanged until it is taken; the block accepts
// no input until the final result has gone. Reset empties the load, sets
// the size to eight and drops out_valid; the stores hold no reset value.
module matrix_inverse_gauss_jordan_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  signed [31:0] element,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] value,
  output logic               singular,
  output logic               overflow,
  output logic               last
);
  import mig_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_PIV_RD, S_PIV_CHK, S_ROW_RD, S_ROW_WR, S_R_SEL,
    S_M_GO, S_M_W, S_E_RD, S_E_MW, S_E_MI, S_E_WR, S_PR_GO, S_PR_W,
    S_PI_GO, S_PI_W, S_O_RD, S_O_LD, S_SING, S_O_SHOW
  } state_t;

  state_t            state;
  logic [3:0]        matrix_size;
  logic [TW-1:0]     load_count;
  logic [DW-1:0]     p, r, j;
  logic [AW-1:0]     pbase, rbase, k;
  logic signed [31:0] t, m, ew, ei, nw, pw;
  logic              msat, sw, ps;
  logic signed [31:0] prow_w [MAX_DIM];
  logic signed [31:0] prow_i [MAX_DIM];
  logic [CELLS-1:0]  marks;

  // Working and inverse stores.
  logic signed [31:0] work_mem [CELLS];
  logic signed [31:0] inv_mem  [CELLS];
  logic signed [31:0] w_q, i_q, w_wd, i_wd;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              w_we, i_we;

  logic [NW-1:0]     n;
  logic [DW-1:0]     last_idx;
  logic [TW-1:0]     total;
  logic              cfg_wr, in_acc;

  always_comb begin
    if (matrix_size == 4'd0) begin
      n = NW'(1);
    end else if (matrix_size > 4'(MAX_DIM)) begin
      n = NW'(MAX_DIM);
    end else begin
      n = matrix_size[NW-1:0];
    end
  end
  assign last_idx = DW'(n - NW'(1));
  assign total    = TW'(n) * TW'(n);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_MATRIX_SIZE) ? {28'd0, matrix_size} : 32'd0;

  // Shared divider: (|x| << FRAC_BITS) / |t|, one quotient bit per cycle.
  logic              div_start, div_neg, div_sat, div_done;
  logic signed [31:0] div_x, div_res;
  logic [QW-1:0]     dvd;
  logic [31:0]       rem, dsr;
  logic [32:0]       trial;
  logic [CW-1:0]     div_cnt;

  assign div_start = (state == S_M_GO) || (state == S_PR_GO) || (state == S_PI_GO);
  assign div_x     = (state == S_M_GO) ? w_q : (state == S_PR_GO) ? prow_w[j] : prow_i[j];
  assign div_done  = (div_cnt == '0);
  assign trial     = {rem, dvd[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_start) begin
      rem     <= '0;
      dvd     <= {mag(div_x), {FRAC_BITS{1'b0}}};
      dsr     <= mag(t);
      div_neg <= div_x[31] ^ t[31];
      div_cnt <= CW'(QW);
    end else if (!div_done) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= 32'(trial - {1'b0, dsr});
        dvd <= {dvd[QW-2:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        dvd <= {dvd[QW-2:0], 1'b0};
      end
      div_cnt <= div_cnt - CW'(1);
    end
  end

  always_comb begin
    div_sat = 1'b0;
    if (div_neg) begin
      if (dvd > {{(QW-32){1'b0}}, 32'h8000_0000}) begin
        div_sat = 1'b1;
        div_res = S_MIN;
      end else begin
        div_res = ~dvd[31:0] + 32'd1;
      end
    end else if (dvd > {{(QW-32){1'b0}}, 32'h7fff_ffff}) begin
      div_sat = 1'b1;
      div_res = S_MAX;
    end else begin
      div_res = dvd[31:0];
    end
  end

  // Shared multiplier, registered, then one subtract with saturation.
  logic signed [31:0] mul_b, sub_a, sub_res;
  logic [63:0]       prod;
  logic              pneg, sub_sat;
  logic signed [63:0] sp, diff;

  assign mul_b = (state == S_E_MW) ? prow_w[j] : prow_i[j];

  always_ff @(posedge clk) begin
    prod <= mag(m) * mag(mul_b);
    pneg <= m[31] ^ mul_b[31];
  end

  assign sp    = pneg ? -$signed(prod >> FRAC_BITS) : $signed(prod >> FRAC_BITS);
  assign sub_a = (state == S_E_MI) ? ew : ei;
  assign diff  = 64'(sub_a) - sp;

  always_comb begin
    sub_sat = 1'b0;
    if (diff > 64'(S_MAX)) begin
      sub_sat = 1'b1;
      sub_res = S_MAX;
    end else if (diff < 64'(S_MIN)) begin
      sub_sat = 1'b1;
      sub_res = S_MIN;
    end else begin
      sub_res = diff[31:0];
    end
  end

  // Store ports.
  always_comb begin
    w_we = 1'b0;
    i_we = 1'b0;
    w_wd = pw;
    i_wd = div_res;
    rd_addr = rbase + AW'(j);
    wr_addr = rbase + AW'(j);
    unique case (state)
      S_LOAD: begin
        w_we    = in_acc;
        w_wd    = element;
        wr_addr = load_count[AW-1:0];
      end
      S_INIT: begin
        i_we = 1'b1;
        i_wd = (r == j) ? ONE : 32'sd0;
      end
      S_PIV_RD: rd_addr = pbase + AW'(p);
      S_ROW_RD: rd_addr = pbase + AW'(j);
      S_R_SEL:  rd_addr = rbase + AW'(p);
      S_E_WR: begin
        w_we = 1'b1;
        i_we = 1'b1;
        w_wd = nw;
        i_wd = sub_res;
      end
      S_PI_W: begin
        w_we    = div_done;
        i_we    = div_done;
        wr_addr = pbase + AW'(j);
      end
      S_O_RD: rd_addr = k;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      work_mem[wr_addr] <= w_wd;
    end
    if (i_we) begin
      inv_mem[wr_addr] <= i_wd;
    end
    w_q <= work_mem[rd_addr];
    i_q <= inv_mem[rd_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      matrix_size <= 4'(MAX_DIM);
      load_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (load_count + TW'(1) >= total) begin
              load_count <= '0;
              marks      <= '0;
              r          <= '0;
              j          <= '0;
              rbase      <= '0;
              state      <= S_INIT;
            end else begin
              load_count <= load_count + TW'(1);
            end
          end
        end
        S_INIT: begin
          if (j == last_idx) begin
            j <= '0;
            if (r == last_idx) begin
              p     <= '0;
              pbase <= '0;
              state <= S_PIV_RD;
            end else begin
              r     <= r + DW'(1);
              rbase <= rbase + AW'(n);
            end
          end else begin
            j <= j + DW'(1);
          end
        end
        S_PIV_RD: state <= S_PIV_CHK;
        S_PIV_CHK: begin
          t <= w_q;
          j <= '0;
          state <= (w_q == 32'sd0) ? S_SING : S_ROW_RD;
        end
        S_ROW_RD: state <= S_ROW_WR;
        S_ROW_WR: begin
          prow_w[j] <= w_q;
          prow_i[j] <= i_q;
          if (j == last_idx) begin
            j     <= '0;
            r     <= '0;
            rbase <= '0;
            state <= S_R_SEL;
          end else begin
            j     <= j + DW'(1);
            state <= S_ROW_RD;
          end
        end
        S_R_SEL: begin
          if (r != p) begin
            state <= S_M_GO;
          end else if (r == last_idx) begin
            j     <= '0;
            state <= S_PR_GO;
          end else begin
            r     <= r + DW'(1);
            rbase <= rbase + AW'(n);
          end
        end
        S_M_GO: state <= S_M_W;
        S_M_W: begin
          if (div_done) begin
            m     <= div_res;
            msat  <= div_sat;
            j     <= '0;
            state <= S_E_RD;
          end
        end
        S_E_RD: state <= S_E_MW;
        S_E_MW: begin
          ew    <= w_q;
          ei    <= i_q;
          state <= S_E_MI;
        end
        S_E_MI: begin
          nw    <= sub_res;
          sw    <= sub_sat;
          state <= S_E_WR;
        end
        S_E_WR: begin
          if (msat || sw || sub_sat) begin
            marks[wr_addr] <= 1'b1;
          end
          if (j != last_idx) begin
            j     <= j + DW'(1);
            state <= S_E_RD;
          end else begin
            j <= '0;
            if (r == last_idx) begin
              state <= S_PR_GO;
            end else begin
              r     <= r + DW'(1);
              rbase <= rbase + AW'(n);
              state <= S_R_SEL;
            end
          end
        end
        S_PR_GO: state <= S_PR_W;
        S_PR_W: begin
          if (div_done) begin
            pw    <= div_res;
            ps    <= div_sat;
            state <= S_PI_GO;
          end
        end
        S_PI_GO: state <= S_PI_W;
        S_PI_W: begin
          if (div_done) begin
            if (ps || div_sat) begin
              marks[wr_addr] <= 1'b1;
            end
            if (j != last_idx) begin
              j     <= j + DW'(1);
              state <= S_PR_GO;
            end else begin
              j <= '0;
              if (p == last_idx) begin
                k     <= '0;
                state <= S_O_RD;
              end else begin
                p     <= p + DW'(1);
                pbase <= pbase + AW'(n);
                state <= S_PIV_RD;
              end
            end
          end
        end
        S_O_RD: state <= S_O_LD;
        S_O_LD: begin
          out_valid <= 1'b1;
          value     <= i_q;
          singular  <= 1'b0;
          overflow  <= marks[k];
          last      <= (TW'(k) + TW'(1) == total);
          state     <= S_O_SHOW;
        end
        S_SING: begin
          out_valid <= 1'b1;
          value     <= 32'sd0;
          singular  <= 1'b1;
          overflow  <= 1'b0;
          last      <= 1'b1;
          state     <= S_O_SHOW;
        end
        S_O_SHOW: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_LOAD;
            end else begin
              k     <= k + AW'(1);
              state <= S_O_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
      if (cfg_wr && paddr[2] == REG_MATRIX_SIZE) begin
        matrix_size <= pwdata[3:0];
        load_count  <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // Input is only taken while no result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid) else $error("input open while a result is pending");
  // A singular run yields one zero item that closes the run.
  a_singular: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> last && value == 32'sd0 && !overflow)
    else $error("malformed singular item");
  // After the final item is taken nothing more is offered.
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && !out_stall |=> !out_valid && !in_stall)
    else $error("result offered after the final item");
`endif

endmodule
`default_nettype wire
